### sv/npc_pkg.sv
// shared types, constants and arithmetic helpers for the nearest palette colour unit
package npc_pkg;

    localparam int NUM_ENTRIES = 8;
    localparam int IDX_W       = 3;
    localparam int CH_W        = 8;
    localparam int COLOUR_W    = 3 * CH_W;
    localparam int SQ_W        = 2 * CH_W;
    localparam int SUM_W       = 18;
    localparam int WORK_W      = 20;
    localparam int DIST_W      = 9;
    localparam int SQRT_ITERS  = 10;
    localparam int CFG_IDX_W   = 4;

    // colour word: red 23:16, green 15:8, blue 7:0
    typedef logic [COLOUR_W-1:0] t_colour;

    // running state of the digit-by-digit square root for one entry
    typedef struct packed {
        logic [WORK_W-1:0] rem;
        logic [WORK_W-1:0] root;
    } t_sqrt_lane;

    // candidate for the minimum search
    typedef struct packed {
        logic              ok;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] distance;
    } t_cand;

    // squared absolute difference of two channels
    function automatic logic [SQ_W-1:0] sq_diff(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
        logic [CH_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

    // one step of the square root, step k uses the bit 4^(SQRT_ITERS-1-k)
    function automatic t_sqrt_lane sqrt_iter(t_sqrt_lane x, int unsigned k);
        logic [WORK_W-1:0] bitv;
        logic [WORK_W-1:0] trial;
        t_sqrt_lane        y;
        bitv  = WORK_W'(1) << (2 * (SQRT_ITERS - 1 - k));
        trial = x.root + bitv;
        if (x.rem >= trial) begin
            y.rem  = x.rem - trial;
            y.root = (x.root >> 1) + bitv;
        end else begin
            y.rem  = x.rem;
            y.root = x.root >> 1;
        end
        return y;
    endfunction

    // a is the lower index, so it wins a tie
    function automatic t_cand pick(t_cand a, t_cand b);
        if (a.ok && (!b.ok || a.distance <= b.distance)) begin
            return a;
        end
        return b;
    endfunction

endpackage

### sv/npc_dist.sv
// first pipeline stage: summed squared channel differences for every palette entry
module npc_dist #(
    parameter int PALETTE_SIZE = 8
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  npc_pkg::t_colour    i_pixel,
    input  npc_pkg::t_colour    i_palette [npc_pkg::NUM_ENTRIES],
    output npc_pkg::t_sqrt_lane o_lane    [PALETTE_SIZE]
);

    npc_pkg::t_sqrt_lane n_lane [PALETTE_SIZE];
    npc_pkg::t_sqrt_lane r_lane [PALETTE_SIZE];

    // squares per channel, summed, root starts at zero
    always_comb begin
        logic [npc_pkg::SUM_W-1:0] sum;
        for (int i = 0; i < PALETTE_SIZE; i++) begin
            sum = npc_pkg::SUM_W'(npc_pkg::sq_diff(i_pixel[23:16], i_palette[i][23:16]))
                + npc_pkg::SUM_W'(npc_pkg::sq_diff(i_pixel[15:8],  i_palette[i][15:8]))
                + npc_pkg::SUM_W'(npc_pkg::sq_diff(i_pixel[7:0],   i_palette[i][7:0]));
            n_lane[i].rem  = npc_pkg::WORK_W'(sum);
            n_lane[i].root = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

### sv/npc_sqrt_stage.sv
// pipeline stage running a few steps of the integer square root on every entry
module npc_sqrt_stage #(
    parameter int PALETTE_SIZE = 8,
    parameter int FIRST_ITER   = 0,
    parameter int NUM_ITER     = 4
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  npc_pkg::t_sqrt_lane i_lane [PALETTE_SIZE],
    output npc_pkg::t_sqrt_lane o_lane [PALETTE_SIZE]
);

    npc_pkg::t_sqrt_lane n_lane [PALETTE_SIZE];
    npc_pkg::t_sqrt_lane r_lane [PALETTE_SIZE];

    // chain of root steps, independent per entry
    always_comb begin
        npc_pkg::t_sqrt_lane x;
        for (int i = 0; i < PALETTE_SIZE; i++) begin
            x = i_lane[i];
            for (int k = 0; k < NUM_ITER; k++) begin
                x = npc_pkg::sqrt_iter(x, FIRST_ITER + k);
            end
            n_lane[i] = x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

### sv/npc_argmin.sv
// minimum search, first two tree levels: eight candidates down to two
module npc_argmin #(
    parameter int PALETTE_SIZE = 8
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  npc_pkg::t_sqrt_lane i_lane [PALETTE_SIZE],
    output npc_pkg::t_cand      o_cand [2]
);

    npc_pkg::t_cand leaf  [npc_pkg::NUM_ENTRIES];
    npc_pkg::t_cand mid   [4];
    npc_pkg::t_cand n_cand [2];
    npc_pkg::t_cand r_cand [2];

    // leaves, entries outside the palette never qualify
    always_comb begin
        for (int i = 0; i < npc_pkg::NUM_ENTRIES; i++) begin
            leaf[i].ok       = 1'b0;
            leaf[i].idx      = npc_pkg::IDX_W'(i);
            leaf[i].distance = '0;
        end
        for (int i = 0; i < PALETTE_SIZE; i++) begin
            leaf[i].ok       = 1'b1;
            leaf[i].distance = i_lane[i].root[npc_pkg::DIST_W-1:0];
        end
    end

    // two levels of pairwise picks, lower index always on the left
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            mid[j] = npc_pkg::pick(leaf[2*j], leaf[2*j+1]);
        end
        for (int j = 0; j < 2; j++) begin
            n_cand[j] = npc_pkg::pick(mid[2*j], mid[2*j+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cand <= n_cand;
        end
    end

    assign o_cand = r_cand;

endmodule

### sv/nearest_palette_color_unit.sv
// top level of the nearest palette colour unit: palette registers, pipeline control, output
// Takes one RGB pixel per clock and returns the index, colour and truncated Euclidean
// distance of the nearest of the first PALETTE_SIZE palette entries; on equal truncated
// distance the lowest index wins. Sustained rate, without output stalls, is one pixel
// per cycle: the pipeline runs distance squares, three square root stages, a two-level
// minimum tree and a final pick with colour lookup, each one register stage. Each stage
// holds its item until the next one is free, so stalls on the output lose nothing and
// bubbles are squeezed out. The palette is written through the configuration port
// (index 0..7, higher indexes ignored) and must only change while the pipeline is empty.
module nearest_palette_color_unit #(
    parameter int PALETTE_SIZE = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [npc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [npc_pkg::COLOUR_W-1:0]  i_cfg_data,
    // pixel input
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [23:0]                   i_s_tdata,  // pixel_red, pixel_green, pixel_blue
    // result output
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [39:0]                   o_m_tdata   // best_index, best_red, best_green,
                                                      // best_blue, best_distance, zero pad
);

    localparam int NUM_STAGES = 6;
    localparam int S_DIST     = 0;
    localparam int S_SQRT_A   = 1;
    localparam int S_SQRT_B   = 2;
    localparam int S_SQRT_C   = 3;
    localparam int S_MIN      = 4;
    localparam int S_OUT      = 5;

    npc_pkg::t_colour    r_palette [npc_pkg::NUM_ENTRIES];
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] stage_en;
    npc_pkg::t_colour    pixel;
    npc_pkg::t_sqrt_lane lane_dist [PALETTE_SIZE];
    npc_pkg::t_sqrt_lane lane_a    [PALETTE_SIZE];
    npc_pkg::t_sqrt_lane lane_b    [PALETTE_SIZE];
    npc_pkg::t_sqrt_lane lane_c    [PALETTE_SIZE];
    npc_pkg::t_cand      cand      [2];
    npc_pkg::t_cand      n_best;
    logic [npc_pkg::IDX_W-1:0]    r_out_idx;
    npc_pkg::t_colour             r_out_colour;
    logic [npc_pkg::DIST_W-1:0]   r_out_dist;

    // palette registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < npc_pkg::NUM_ENTRIES; i++) begin
                r_palette[i] <= '0;
            end
        end else if (i_cfg_we &&
                     i_cfg_index < npc_pkg::CFG_IDX_W'(npc_pkg::NUM_ENTRIES)) begin
            r_palette[i_cfg_index[npc_pkg::IDX_W-1:0]] <= i_cfg_data;
        end
    end

    // stage advances when empty or when the stage after it advances
    always_comb begin
        stage_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_tready = stage_en[S_DIST];

    // repack the incoming pixel as a colour word
    assign pixel = {i_s_tdata[7:0], i_s_tdata[15:8], i_s_tdata[23:16]};

    npc_dist #(
        .PALETTE_SIZE(PALETTE_SIZE)
    ) u_dist (
        .i_clk     (i_clk),
        .i_en      (stage_en[S_DIST]),
        .i_pixel   (pixel),
        .i_palette (r_palette),
        .o_lane    (lane_dist)
    );

    npc_sqrt_stage #(
        .PALETTE_SIZE(PALETTE_SIZE),
        .FIRST_ITER  (0),
        .NUM_ITER    (4)
    ) u_sqrt_a (
        .i_clk  (i_clk),
        .i_en   (stage_en[S_SQRT_A]),
        .i_lane (lane_dist),
        .o_lane (lane_a)
    );

    npc_sqrt_stage #(
        .PALETTE_SIZE(PALETTE_SIZE),
        .FIRST_ITER  (4),
        .NUM_ITER    (3)
    ) u_sqrt_b (
        .i_clk  (i_clk),
        .i_en   (stage_en[S_SQRT_B]),
        .i_lane (lane_a),
        .o_lane (lane_b)
    );

    npc_sqrt_stage #(
        .PALETTE_SIZE(PALETTE_SIZE),
        .FIRST_ITER  (7),
        .NUM_ITER    (3)
    ) u_sqrt_c (
        .i_clk  (i_clk),
        .i_en   (stage_en[S_SQRT_C]),
        .i_lane (lane_b),
        .o_lane (lane_c)
    );

    npc_argmin #(
        .PALETTE_SIZE(PALETTE_SIZE)
    ) u_argmin (
        .i_clk  (i_clk),
        .i_en   (stage_en[S_MIN]),
        .i_lane (lane_c),
        .o_cand (cand)
    );

    // last tree level and colour lookup into the output register
    assign n_best = npc_pkg::pick(cand[0], cand[1]);

    always_ff @(posedge i_clk) begin
        if (stage_en[S_OUT]) begin
            r_out_idx    <= n_best.idx;
            r_out_colour <= r_palette[n_best.idx];
            r_out_dist   <= n_best.distance;
        end
    end

    assign o_m_tvalid = r_vld[S_OUT];
    assign o_m_tdata  = {4'b0000, r_out_dist, r_out_colour[7:0], r_out_colour[15:8],
                         r_out_colour[23:16], r_out_idx};

    // an empty output stage means the whole pipeline can move
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input not ready although output stage is empty");

    // a full pipeline with a stalled output takes nothing
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld && !i_m_tready) |-> !o_s_tready)
        else $error("full pipeline accepted a transfer during a stall");

    // distance stays within the range of the colour cube
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[35:27] <= 9'd441))
        else $error("distance out of range");

    // chosen entry lies inside the searched palette
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (32'(o_m_tdata[2:0]) < PALETTE_SIZE))
        else $error("chosen index outside the palette");

endmodule
